### rtl/core/fss_pkg.sv
package fss_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_RXBYTE = 2'd1;
    localparam logic [1:0] OP_WINDOW = 2'd2;

    // result kinds
    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_RX_ERR     = 4'd1;
    localparam logic [3:0] ST_NO_FINGER  = 4'd2;
    localparam logic [3:0] ST_CAPT_FAIL  = 4'd3;
    localparam logic [3:0] ST_DISORDER   = 4'd4;
    localparam logic [3:0] ST_TOO_SMALL  = 4'd5;
    localparam logic [3:0] ST_INVALID    = 4'd6;
    localparam logic [3:0] ST_COMB_FAIL  = 4'd7;
    localparam logic [3:0] ST_NO_MATCH   = 4'd8;
    localparam logic [3:0] ST_SHORT      = 4'd9;
    localparam logic [3:0] ST_UNKNOWN    = 4'd10;

    // command steps
    localparam logic [2:0] STG_CAPT1  = 3'd0;
    localparam logic [2:0] STG_CONV1  = 3'd1;
    localparam logic [2:0] STG_CAPT2  = 3'd2;
    localparam logic [2:0] STG_CONV2  = 3'd3;
    localparam logic [2:0] STG_COMB   = 3'd4;
    localparam logic [2:0] STG_SEARCH = 3'd5;

    // reply byte positions and minimum reply lengths
    localparam logic [5:0] POS_CONFIRM = 6'd9;
    localparam logic [5:0] POS_PAGE    = 6'd11;
    localparam logic [5:0] NEED_NORMAL = 6'd11;
    localparam logic [5:0] NEED_SEARCH = 6'd15;

    // module confirmation codes
    localparam logic [7:0] CC_OK        = 8'h00;
    localparam logic [7:0] CC_RX_ERR    = 8'h01;
    localparam logic [7:0] CC_NO_FINGER = 8'h02;
    localparam logic [7:0] CC_CAPT_FAIL = 8'h03;
    localparam logic [7:0] CC_DISORDER  = 8'h06;
    localparam logic [7:0] CC_TOO_SMALL = 8'h07;
    localparam logic [7:0] CC_INVALID   = 8'h15;
    localparam logic [7:0] CC_COMB_FAIL = 8'h0A;
    localparam logic [7:0] CC_NO_MATCH  = 8'h09;

    localparam int RX_LIMIT_DEF = 32;
    localparam int PKT_MAX      = 17;

    // command packets, padded to the longest one
    localparam logic [7:0] PKT_BYTES [6][PKT_MAX] = '{
        '{8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h03, 8'h01,
          8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h04, 8'h02,
          8'h01, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h03, 8'h01,
          8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h04, 8'h02,
          8'h02, 8'h00, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h03, 8'h05,
          8'h00, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h08, 8'h04,
          8'h01, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h18}
    };

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_data;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [2:0] stage;
        logic [3:0] status;
        logic       sequence_done;
        logic [7:0] match_page;
    } t_out;

    // one run of results caused by a single input beat
    typedef struct packed {
        logic       has_status;
        logic       status_last;
        logic [2:0] stage;
        logic [3:0] status;
        logic       done;
        logic [7:0] page;
        logic       has_pkt;
        logic [2:0] pkt_stage;
    } t_run;

    function automatic logic [2:0] clamp_stage(input logic [2:0] s);
        return (s > STG_SEARCH) ? STG_SEARCH : s;
    endfunction

    function automatic logic [4:0] pkt_len(input logic [2:0] s);
        logic [4:0] n;
        unique case (clamp_stage(s))
            STG_CAPT1, STG_CAPT2, STG_COMB: n = 5'd12;
            STG_CONV1, STG_CONV2:           n = 5'd13;
            default:                        n = 5'd17;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] pkt_byte(input logic [2:0] s, input logic [4:0] i);
        logic [7:0] b;
        b = 8'h00;
        if (i < 5'(PKT_MAX)) begin
            b = PKT_BYTES[clamp_stage(s)][i];
        end
        return b;
    endfunction

    // map a confirmation code to a status for the given step
    function automatic logic [3:0] judge(input logic [2:0] s, input logic [7:0] cc);
        logic [3:0] st;
        st = ST_UNKNOWN;
        if (cc == CC_OK) begin
            st = ST_OK;
        end else if (cc == CC_RX_ERR) begin
            st = ST_RX_ERR;
        end else begin
            unique case (s)
                STG_CAPT1, STG_CAPT2: begin
                    if (cc == CC_NO_FINGER) st = ST_NO_FINGER;
                    else if (cc == CC_CAPT_FAIL) st = ST_CAPT_FAIL;
                end
                STG_CONV1, STG_CONV2: begin
                    if (cc == CC_DISORDER) st = ST_DISORDER;
                    else if (cc == CC_TOO_SMALL) st = ST_TOO_SMALL;
                    else if (cc == CC_INVALID) st = ST_INVALID;
                end
                STG_COMB: begin
                    if (cc == CC_COMB_FAIL) st = ST_COMB_FAIL;
                end
                default: begin
                    if (cc == CC_NO_MATCH) st = ST_NO_MATCH;
                end
            endcase
        end
        return st;
    endfunction

endpackage

### rtl/core/fss_ctrl.sv
module fss_ctrl #(
    parameter int RX_LIMIT = fss_pkg::RX_LIMIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_fire,
    input  fss_pkg::t_in i_in,
    output logic         o_run_valid,
    output fss_pkg::t_run o_run
);
    import fss_pkg::*;

    localparam int         COUNT_CAP = (RX_LIMIT < 63) ? RX_LIMIT : 63;
    localparam logic [5:0] CAP       = 6'(COUNT_CAP);

    logic [2:0] r_step, n_step;
    logic       r_busy, n_busy;
    logic [5:0] r_count, n_count;
    logic [7:0] r_confirm, n_confirm;
    logic [7:0] r_page, n_page;

    logic [2:0] cur_stage;
    logic [5:0] need;
    logic [3:0] st;

    // judge the current reply
    always_comb begin
        cur_stage = clamp_stage(r_step);
        need      = (cur_stage == STG_SEARCH) ? NEED_SEARCH : NEED_NORMAL;
        st        = (r_count < need) ? ST_SHORT : judge(cur_stage, r_confirm);
    end

    // next state and the run descriptor
    always_comb begin
        n_step      = r_step;
        n_busy      = r_busy;
        n_count     = r_count;
        n_confirm   = r_confirm;
        n_page      = r_page;
        o_run_valid = 1'b0;
        o_run       = '0;
        if (i_fire) begin
            unique case (i_in.op)
                OP_START: begin
                    n_step          = STG_CAPT1;
                    n_busy          = 1'b1;
                    n_count         = '0;
                    n_confirm       = '0;
                    n_page          = '0;
                    o_run_valid     = 1'b1;
                    o_run.has_pkt   = 1'b1;
                    o_run.pkt_stage = STG_CAPT1;
                end
                OP_RXBYTE: begin
                    if (r_busy) begin
                        if (r_count == POS_CONFIRM) n_confirm = i_in.rx_data;
                        if (r_count == POS_PAGE) n_page = i_in.rx_data;
                        if (r_count < CAP) n_count = r_count + 6'd1;
                    end
                end
                OP_WINDOW: begin
                    if (r_busy) begin
                        o_run_valid      = 1'b1;
                        o_run.has_status = 1'b1;
                        o_run.stage      = cur_stage;
                        o_run.status     = st;
                        if (st != ST_OK || cur_stage == STG_SEARCH) begin
                            o_run.status_last = 1'b1;
                            o_run.done        = 1'b1;
                            o_run.page        = (st == ST_OK) ? r_page : 8'h00;
                            n_busy            = 1'b0;
                        end else begin
                            o_run.has_pkt   = 1'b1;
                            o_run.pkt_stage = cur_stage + 3'd1;
                            n_step          = cur_stage + 3'd1;
                            n_count         = '0;
                            n_confirm       = '0;
                            n_page          = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_confirm <= '0;
            r_page    <= '0;
        end else begin
            r_step    <= n_step;
            r_busy    <= n_busy;
            r_count   <= n_count;
            r_confirm <= n_confirm;
            r_page    <= n_page;
        end
    end

endmodule

### rtl/core/fss_emit.sv
module fss_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_run_valid,
    input  fss_pkg::t_run i_run,
    output logic          o_free,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fss_pkg::t_out o_out
);
    import fss_pkg::*;

    logic       r_active;
    logic       r_pending;
    t_run       r_run;
    logic [4:0] r_idx;
    logic       r_ovalid;
    t_out       r_out;

    t_out       beat;
    logic       beat_last;
    logic       load;

    // current beat of the run
    always_comb begin
        beat = '0;
        if (r_pending) begin
            beat.kind          = KIND_STATUS;
            beat.last          = r_run.status_last;
            beat.stage         = r_run.stage;
            beat.status        = r_run.status;
            beat.sequence_done = r_run.done;
            beat.match_page    = r_run.page;
        end else begin
            beat.kind    = KIND_CMD;
            beat.tx_byte = pkt_byte(r_run.pkt_stage, r_idx);
            beat.last    = (r_idx == pkt_len(r_run.pkt_stage) - 5'd1);
            beat.stage   = clamp_stage(r_run.pkt_stage);
        end
        beat_last = beat.last;
    end

    assign load   = r_active && (!r_ovalid || i_out_ready);
    assign o_free = !r_active || (load && beat_last);

    // run sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_pending <= 1'b0;
            r_idx     <= '0;
        end else if (i_run_valid) begin
            r_active  <= 1'b1;
            r_pending <= i_run.has_status;
            r_idx     <= '0;
        end else if (load) begin
            if (beat_last) begin
                r_active <= 1'b0;
            end
            if (r_pending) begin
                r_pending <= 1'b0;
            end else begin
                r_idx <= r_idx + 5'd1;
            end
        end
    end

    // run descriptor
    always_ff @(posedge i_clk) begin
        if (i_run_valid) begin
            r_run <= i_run;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (!r_ovalid || i_out_ready) begin
            r_ovalid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= beat;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

### rtl/core/fingerprint_search_sequencer.sv
// channel  | valid          | ready          | payload
// input    | i_in_valid     | o_in_ready     | i_in  (op, rx_data)
// result   | o_out_valid    | i_out_ready    | o_out (kind .. match_page)
//
// an input beat is taken when o_in_ready is high; its results leave one per cycle from a
// result register while i_out_ready does not stall them, so a start yields 12 results and a
// window-over up to 18, set by the packet sequencer stepping through the command table.
// a byte or an ignored beat produces nothing.
// reset (synchronous, active low) idles the sequence and empties the result register.
// a stalled result holds; a new input is taken in the cycle the last result of a run is loaded.
module fingerprint_search_sequencer #(
    parameter int RX_LIMIT = fss_pkg::RX_LIMIT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fss_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fss_pkg::t_out o_out
);
    import fss_pkg::*;

    logic fire;
    logic run_valid;
    t_run run;
    logic free;

    assign o_in_ready = free;
    assign fire       = i_in_valid && free;

    // command state and reply judging
    fss_ctrl #(
        .RX_LIMIT (RX_LIMIT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_in        (i_in),
        .o_run_valid (run_valid),
        .o_run       (run)
    );

    // result run sequencing
    fss_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (run_valid),
        .i_run       (run),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### dv/fss_checker.sv
module fss_checker #(
    parameter int RX_LIMIT = fss_pkg::RX_LIMIT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  fss_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  fss_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_beat_count,
    output int            o_result_count,
    output int            o_match_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fss_pkg::*;

    localparam int COUNT_CAP = (RX_LIMIT < 63) ? RX_LIMIT : 63;
    localparam int HEAD_LEN  = 8;

    // shared packet header, then the per-command tail
    localparam logic [7:0] CMD_HEAD [0:7] = '{
        8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00
    };
    localparam logic [7:0] CMD_TAIL [0:5][0:8] = '{
        '{8'h03, 8'h01, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h02, 8'h01, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h03, 8'h01, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h02, 8'h02, 8'h00, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h03, 8'h05, 8'h00, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h08, 8'h04, 8'h01, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h18}
    };
    localparam int TAIL_LEN [0:5] = '{4, 5, 4, 5, 4, 9};

    // sequencer state as seen from outside
    logic [2:0] cur_stage;
    logic       running;
    int         reply_bytes;
    logic [7:0] kept_confirm;
    logic [7:0] kept_page;

    t_out owed_results [$];
    t_out want;
    int   miss_total;
    int   beat_total;
    int   result_total;
    int   match_total;

    function automatic string show(input t_out r);
        return $sformatf("kind=%0d tx=%02h last=%0d stage=%0d status=%0d done=%0d page=%02h",
                         r.kind, r.tx_byte, r.last, r.stage, r.status, r.sequence_done,
                         r.match_page);
    endfunction

    // confirmation code to status for one command step
    function automatic logic [3:0] confirm_to_status(input logic [2:0] stg,
                                                     input logic [7:0] code);
        logic [3:0] st;
        st = ST_UNKNOWN;
        if (code == CC_OK) begin
            st = ST_OK;
        end else if (code == CC_RX_ERR) begin
            st = ST_RX_ERR;
        end else begin
            case (stg)
                STG_CAPT1, STG_CAPT2: begin
                    if (code == CC_NO_FINGER) st = ST_NO_FINGER;
                    if (code == CC_CAPT_FAIL) st = ST_CAPT_FAIL;
                end
                STG_CONV1, STG_CONV2: begin
                    if (code == CC_DISORDER) st = ST_DISORDER;
                    if (code == CC_TOO_SMALL) st = ST_TOO_SMALL;
                    if (code == CC_INVALID) st = ST_INVALID;
                end
                STG_COMB: begin
                    if (code == CC_COMB_FAIL) st = ST_COMB_FAIL;
                end
                default: begin
                    if (code == CC_NO_MATCH) st = ST_NO_MATCH;
                end
            endcase
        end
        return st;
    endfunction

    function automatic t_out status_report(input logic [2:0] stg, input logic [3:0] st,
                                           input logic fin, input logic [7:0] page);
        t_out r;
        r = '0;
        r.kind          = KIND_STATUS;
        r.last          = fin;
        r.stage         = stg;
        r.status        = st;
        r.sequence_done = fin;
        r.match_page    = page;
        return r;
    endfunction

    // every new command starts from an empty reply
    task automatic clear_reply();
        reply_bytes  = 0;
        kept_confirm = 8'h00;
        kept_page    = 8'h00;
    endtask

    task automatic queue_packet(input logic [2:0] stg);
        int   n;
        int   i;
        t_out r;
        n = HEAD_LEN + TAIL_LEN[stg];
        for (i = 0; i < n; i++) begin
            r         = '0;
            r.kind    = KIND_CMD;
            r.tx_byte = (i < HEAD_LEN) ? CMD_HEAD[i] : CMD_TAIL[stg][i - HEAD_LEN];
            r.last    = (i == n - 1);
            r.stage   = stg;
            owed_results.push_back(r);
        end
    endtask

    // advance the sequence by one input beat and queue what it owes
    task automatic sequence_step(input t_in beat);
        logic [2:0] stg;
        int         need;
        logic [3:0] st;
        case (beat.op)
            OP_START: begin
                cur_stage = STG_CAPT1;
                running   = 1'b1;
                clear_reply();
                queue_packet(STG_CAPT1);
            end
            OP_RXBYTE: begin
                if (running) begin
                    if (reply_bytes == POS_CONFIRM) kept_confirm = beat.rx_data;
                    if (reply_bytes == POS_PAGE) kept_page = beat.rx_data;
                    if (reply_bytes < COUNT_CAP) reply_bytes++;
                end
            end
            OP_WINDOW: begin
                if (running) begin
                    stg  = cur_stage;
                    need = (stg == STG_SEARCH) ? NEED_SEARCH : NEED_NORMAL;
                    st   = (reply_bytes < need) ? ST_SHORT : confirm_to_status(stg, kept_confirm);
                    if (st != ST_OK) begin
                        owed_results.push_back(status_report(stg, st, 1'b1, 8'h00));
                        running = 1'b0;
                    end else if (stg == STG_SEARCH) begin
                        owed_results.push_back(status_report(stg, ST_OK, 1'b1, kept_page));
                        running = 1'b0;
                    end else begin
                        owed_results.push_back(status_report(stg, ST_OK, 1'b0, 8'h00));
                        cur_stage = stg + 3'd1;
                        clear_reply();
                        queue_packet(cur_stage);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_miss(input string what);
        miss_total++;
        if (miss_total <= 10) $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // compare result beats in order, then fold in the new input beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_stage    = STG_CAPT1;
            running      = 1'b0;
            clear_reply();
            owed_results.delete();
            miss_total   = 0;
            beat_total   = 0;
            result_total = 0;
            match_total  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                result_total++;
                if (owed_results.size() == 0) begin
                    note_miss({"unexpected result ", show(i_out)});
                end else begin
                    want = owed_results.pop_front();
                    if (i_out.kind !== want.kind || i_out.tx_byte !== want.tx_byte ||
                        i_out.last !== want.last || i_out.stage !== want.stage ||
                        i_out.status !== want.status ||
                        i_out.sequence_done !== want.sequence_done ||
                        i_out.match_page !== want.match_page) begin
                        note_miss({"expected ", show(want), " got ", show(i_out)});
                    end
                end
                if (i_out.kind == KIND_STATUS && i_out.stage == STG_SEARCH &&
                    i_out.status == ST_OK) begin
                    match_total++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                beat_total++;
                sequence_step(i_in);
            end
        end
        o_fail_count   <= miss_total;
        o_pending      <= owed_results.size();
        o_beat_count   <= beat_total;
        o_result_count <= result_total;
        o_match_count  <= match_total;
    end

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fss_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         PHASE_BEATS = 10;
    localparam int         DRAIN_WAIT  = 24;

    localparam logic [7:0] FAIL_CODES [0:6] = '{
        CC_NO_FINGER, CC_CAPT_FAIL, CC_DISORDER, CC_TOO_SMALL, CC_INVALID,
        CC_COMB_FAIL, CC_NO_MATCH
    };
    localparam logic [1:0] NOISE_OPS [0:2] = '{OP_RXBYTE, OP_WINDOW, OP_UNUSED};

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_beat  = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_beat;

    int fail_count;
    int pending;
    int beat_count;
    int result_count;
    int match_count;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int live_beats     = 0;
    int cycle_count    = 0;
    int phase;
    int phase_mark;

    fingerprint_search_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    fss_checker u_monitor (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in           (in_beat),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out          (out_beat),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_beat_count   (beat_count),
        .o_result_count (result_count),
        .o_match_count  (match_count)
    );

    always #5 clk = ~clk;

    // receiver back-pressure
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one input beat, with an optional gap before it; returns at a falling edge
    task automatic push_beat(input logic [1:0] op, input logic [7:0] data);
        t_in b;
        b.op      = op;
        b.rx_data = data;
        if ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // reply bytes from the module, confirmation code at its slot
    task automatic send_reply(input int len, input logic [7:0] code);
        int         i;
        logic [7:0] b;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < 2) push_beat(OP_UNUSED, 8'($urandom));
            b = 8'($urandom);
            if (i == POS_CONFIRM) b = code;
            push_beat(OP_RXBYTE, b);
            live_beats++;
        end
    endtask

    // a full scan attempt; clean runs always answer well-formed and succeed up to search
    task automatic run_sequence(input bit clean);
        int         stg;
        int         need;
        int         len;
        int         pick;
        logic [7:0] code;
        bit         going;
        if (!clean && $urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 3)) push_beat(NOISE_OPS[$urandom_range(2)], 8'($urandom));
        end
        push_beat(OP_START, 8'($urandom));
        live_beats++;
        stg   = STG_CAPT1;
        going = 1'b1;
        while (going) begin
            need = (stg == STG_SEARCH) ? NEED_SEARCH : NEED_NORMAL;
            pick = $urandom_range(99);
            if (clean || pick >= 12) len = need + $urandom_range(0, 3);
            else if (pick < 6) len = $urandom_range(0, need - 1);
            else len = $urandom_range(RX_LIMIT_DEF + 1, RX_LIMIT_DEF + 8);
            pick = $urandom_range(99);
            if (clean) code = (stg == STG_SEARCH && pick < 50) ? CC_NO_MATCH : CC_OK;
            else if (pick < 60) code = CC_OK;
            else if (pick < 80) code = FAIL_CODES[$urandom_range(6)];
            else if (pick < 88) code = CC_RX_ERR;
            else code = 8'($urandom);
            send_reply(len, code);
            if (!clean && $urandom_range(99) < 3) begin
                // restart in the middle of a command
                push_beat(OP_START, 8'($urandom));
                live_beats++;
                stg = STG_CAPT1;
            end else begin
                push_beat(OP_WINDOW, 8'($urandom));
                live_beats++;
                if (len < need || code != CC_OK || stg == STG_SEARCH) going = 1'b0;
                else stg++;
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // beats while idle and the unused op are dropped
        push_beat(OP_RXBYTE, 8'hFF);
        push_beat(OP_WINDOW, 8'h00);
        push_beat(OP_UNUSED, 8'hFF);
        // start, then an empty reply
        push_beat(OP_START, 8'h00);
        push_beat(OP_WINDOW, 8'hFF);
        // restart while busy clears the partial reply
        push_beat(OP_START, 8'hFF);
        push_beat(OP_RXBYTE, 8'h00);
        push_beat(OP_RXBYTE, 8'hFF);
        push_beat(OP_RXBYTE, 8'hAA);
        push_beat(OP_START, 8'h55);
        send_reply(NEED_NORMAL, CC_OK);
        push_beat(OP_WINDOW, 8'h00);
        // old success must not carry into the next command
        push_beat(OP_WINDOW, 8'h00);

        // random scans under three idle mixes
        for (phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 8 : (phase == 1) ? 74 : 0;
            recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 8 : 0;
            phase_mark     = live_beats;
            if (phase == 0) run_sequence(1'b1);
            while (live_beats - phase_mark < PHASE_BEATS) run_sequence(1'b0);
        end
        in_valid <= 1'b0;

        // drain
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (pending != 0) $display("tb: %0d results never arrived", pending);
        $display("tb: %0d input beats, %0d results checked, %0d search matches",
                 beat_count, result_count, match_count);
        $display("tb: short, saturated, restarted and unknown-code replies under three stall mixes");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
